@@ rtl/tds_pkg.sv @@
// Shared constants, types and fixed-point helpers for the tridiagonal solver.
package tds_pkg;

  localparam int MAX_ROWS  = 32;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int CNT_W     = $clog2(MAX_ROWS + 1);
  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 24;
  localparam int DVD_W     = DATA_W + FRAC_W;
  localparam int DIV_STEPS = DVD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);
  localparam int IDX_OUT_W = 5;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_PIVOT = 2'd1;
  localparam logic [1:0] FAULT_ROWS  = 2'd2;
  localparam logic [1:0] FAULT_SAT   = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_FRD, S_FM1, S_FM2, S_FM3, S_FCHK, S_DIV, S_DEND,
    S_BRD, S_BMUL, S_BSUB, S_OUT
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              ovf;
  } sat_t;

  // clamp a 65-bit signed value to 32 bits
  function automatic sat_t sat_wide(input logic [64:0] v);
    sat_t r;
    r.ovf = !((&v[64:DATA_W-1]) || (~|v[64:DATA_W-1]));
    if (r.ovf) begin
      r.val = v[64] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r.val = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // product >> 24, floor, saturated
  function automatic sat_t qmul(input logic [63:0] p);
    return sat_wide({{(65-64+FRAC_W){p[63]}}, p[63:FRAC_W]});
  endfunction

  // x - y, saturated
  function automatic sat_t sat_sub(input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] y);
    return sat_wide({{(65-DATA_W){x[DATA_W-1]}}, x} - {{(65-DATA_W){y[DATA_W-1]}}, y});
  endfunction

  // signed quotient from magnitude and sign, saturated
  function automatic sat_t quot_sat(input logic [DVD_W-1:0] q, input logic neg);
    sat_t r;
    if (neg) begin
      r.ovf = (|q[DVD_W-1:DATA_W]) || (q[DATA_W-1] && (|q[DATA_W-2:0]));
      r.val = r.ovf ? {1'b1, {(DATA_W-1){1'b0}}} : (~q[DATA_W-1:0] + 1'b1);
    end else begin
      r.ovf = |q[DVD_W-1:DATA_W-1];
      r.val = r.ovf ? {1'b0, {(DATA_W-1){1'b1}}} : q[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/tridiagonal_thomas_solver.sv @@
// Tridiagonal solver top level: forward sweep, shared divider, back substitution.
//
//  channel | ports                                          | dir
//  in      | in_valid in_stall in_sub_diag in_main_diag     | in
//          | in_super_diag in_rhs_value in_last_row         |
//  out     | out_valid out_stall out_solution out_row_index | out
//          | out_last_out out_status                        |
//
// Forward row: two 56-step restoring divisions on one divider; row 0 skips the
// multiply states and a zero pivot skips both divisions.
// Back substitution per item: S_BRD, S_BMUL, S_BSUB (not for the top row), S_OUT.
// Synchronous active-low reset clears the sequencer, row count and fault code.
// The input is stalled while a row or the back substitution is in progress.
// A stalled solution item holds in the output register.
module tridiagonal_thomas_solver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_sub_diag,
  input  logic [31:0] in_main_diag,
  input  logic [31:0] in_super_diag,
  input  logic [31:0] in_rhs_value,
  input  logic        in_last_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_solution,
  output logic [4:0]  out_row_index,
  output logic        out_last_out,
  output logic [1:0]  out_status
);

  localparam int DW = tds_pkg::DATA_W;
  localparam int RW = tds_pkg::ROW_W;
  localparam int CW = tds_pkg::CNT_W;
  localparam int VW = tds_pkg::DVD_W;
  localparam int SW = tds_pkg::STEP_W;
  localparam int OW = tds_pkg::IDX_OUT_W;

  tds_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] row_cnt_r, row_cnt_nxt;
  logic [1:0]    fault_r, fault_nxt;

  logic [DW-1:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, d_r, d_nxt;
  logic          last_r, last_nxt;
  logic [DW-1:0] den_r, den_nxt, num_r, num_nxt;
  logic [63:0]   prod_r, prod_nxt;
  logic [VW-1:0] dq_r, dq_nxt;
  logic [DW-1:0] rem_r, rem_nxt, dmag_r, dmag_nxt;
  logic          dsgn_r, dsgn_nxt, dsel_r, dsel_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [RW-1:0] idx_r, idx_nxt;
  logic          top_r, top_nxt;
  logic [DW-1:0] xprev_r, xprev_nxt, sol_r, sol_nxt;
  logic [1:0]    ostat_r, ostat_nxt;

  logic [DW-1:0] mul_x, mul_y;
  logic [RW-1:0] raddr, waddr;
  logic          cs_we, ds_we;
  logic [DW-1:0] cs_wdata, ds_wdata, cs_rdata, ds_rdata;

  logic [DW:0]   shifted;
  logic [DW+1:0] trial;
  logic          ge;
  tds_pkg::sat_t mq, sr, qr;
  logic [DW-1:0] ld_num, ld_mag;

  tds_ram #(.WIDTH(DW), .DEPTH(tds_pkg::MAX_ROWS)) u_cs_ram (
    .clk(clk), .we(cs_we), .waddr(waddr), .wdata(cs_wdata), .raddr(raddr), .rdata(cs_rdata)
  );

  tds_ram #(.WIDTH(DW), .DEPTH(tds_pkg::MAX_ROWS)) u_ds_ram (
    .clk(clk), .we(ds_we), .waddr(waddr), .wdata(ds_wdata), .raddr(raddr), .rdata(ds_rdata)
  );

  assign waddr = row_cnt_r[RW-1:0];
  assign raddr = (state_r == tds_pkg::S_BRD || state_r == tds_pkg::S_BMUL ||
                  state_r == tds_pkg::S_BSUB) ? idx_r : RW'(row_cnt_r - 1'b1);

  assign in_stall      = (state_r != tds_pkg::S_IDLE);
  assign out_valid     = (state_r == tds_pkg::S_OUT);
  assign out_solution  = sol_r;
  assign out_row_index = OW'(idx_r);
  assign out_last_out  = (idx_r == '0);
  assign out_status    = ostat_r;

  // shared multiplier and divider step
  assign prod_nxt = 64'($signed(mul_x) * $signed(mul_y));
  assign shifted  = {rem_r, dq_r[VW-1]};
  assign trial    = {1'b0, shifted} - {2'b00, dmag_r};
  assign ge       = !trial[DW+1];
  assign mq       = tds_pkg::qmul(prod_r);
  assign qr       = tds_pkg::quot_sat(dq_r, dsgn_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tds_pkg::S_IDLE;
      row_cnt_r <= '0;
      fault_r   <= tds_pkg::FAULT_NONE;
    end else begin
      state_r   <= state_nxt;
      row_cnt_r <= row_cnt_nxt;
      fault_r   <= fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt; d_r <= d_nxt; last_r <= last_nxt;
    den_r <= den_nxt; num_r <= num_nxt; prod_r <= prod_nxt;
    dq_r <= dq_nxt; rem_r <= rem_nxt; dmag_r <= dmag_nxt; dsgn_r <= dsgn_nxt;
    dsel_r <= dsel_nxt; step_r <= step_nxt; idx_r <= idx_nxt; top_r <= top_nxt;
    xprev_r <= xprev_nxt; sol_r <= sol_nxt; ostat_r <= ostat_nxt;
  end

  always_comb begin
    state_nxt = state_r; row_cnt_nxt = row_cnt_r; fault_nxt = fault_r;
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r; last_nxt = last_r;
    den_nxt = den_r; num_nxt = num_r;
    dq_nxt = dq_r; rem_nxt = rem_r; dmag_nxt = dmag_r; dsgn_nxt = dsgn_r;
    dsel_nxt = dsel_r; step_nxt = step_r; idx_nxt = idx_r; top_nxt = top_r;
    xprev_nxt = xprev_r; sol_nxt = sol_r; ostat_nxt = ostat_r;
    mul_x = a_r; mul_y = cs_rdata;
    cs_we = 1'b0; ds_we = 1'b0; cs_wdata = '0; ds_wdata = '0;
    sr = tds_pkg::sat_sub(b_r, mq.val);
    ld_num = c_r;
    ld_mag = '0;

    unique case (state_r)
      tds_pkg::S_IDLE: begin
        if (in_valid) begin
          a_nxt = in_sub_diag; b_nxt = in_main_diag; c_nxt = in_super_diag;
          d_nxt = in_rhs_value; last_nxt = in_last_row;
          if (row_cnt_r >= CW'(tds_pkg::MAX_ROWS)) begin
            if (fault_r == tds_pkg::FAULT_NONE) fault_nxt = tds_pkg::FAULT_ROWS;
            if (in_last_row) begin
              idx_nxt = RW'(row_cnt_r - 1'b1); top_nxt = 1'b1;
              state_nxt = tds_pkg::S_BRD;
            end
          end else if (row_cnt_r == '0) begin
            den_nxt = in_main_diag; num_nxt = in_rhs_value;
            state_nxt = tds_pkg::S_FCHK;
          end else begin
            state_nxt = tds_pkg::S_FRD;
          end
        end
      end
      tds_pkg::S_FRD: state_nxt = tds_pkg::S_FM1;
      tds_pkg::S_FM1: state_nxt = tds_pkg::S_FM2;
      tds_pkg::S_FM2: begin
        mul_y = ds_rdata;
        den_nxt = sr.val;
        if (fault_r == tds_pkg::FAULT_NONE && (mq.ovf || sr.ovf)) fault_nxt = tds_pkg::FAULT_SAT;
        state_nxt = tds_pkg::S_FM3;
      end
      tds_pkg::S_FM3: begin
        sr = tds_pkg::sat_sub(d_r, mq.val);
        num_nxt = sr.val;
        if (fault_r == tds_pkg::FAULT_NONE && (mq.ovf || sr.ovf)) fault_nxt = tds_pkg::FAULT_SAT;
        state_nxt = tds_pkg::S_FCHK;
      end
      tds_pkg::S_FCHK: begin
        if (den_r == '0) begin
          if (fault_r == tds_pkg::FAULT_NONE) fault_nxt = tds_pkg::FAULT_PIVOT;
          cs_we = 1'b1; ds_we = 1'b1;
          row_cnt_nxt = row_cnt_r + 1'b1;
          if (last_r) begin
            idx_nxt = row_cnt_r[RW-1:0]; top_nxt = 1'b1;
            state_nxt = tds_pkg::S_BRD;
          end else begin
            state_nxt = tds_pkg::S_IDLE;
          end
        end else begin
          ld_num = c_r;
          ld_mag = ld_num[DW-1] ? (~ld_num + 1'b1) : ld_num;
          dq_nxt = {ld_mag, {tds_pkg::FRAC_W{1'b0}}};
          rem_nxt = '0;
          dmag_nxt = den_r[DW-1] ? (~den_r + 1'b1) : den_r;
          dsgn_nxt = ld_num[DW-1] ^ den_r[DW-1];
          step_nxt = '0; dsel_nxt = 1'b0;
          state_nxt = tds_pkg::S_DIV;
        end
      end
      tds_pkg::S_DIV: begin
        rem_nxt = ge ? trial[DW-1:0] : shifted[DW-1:0];
        dq_nxt = {dq_r[VW-2:0], ge};
        step_nxt = step_r + 1'b1;
        if (step_r == SW'(tds_pkg::DIV_STEPS - 1)) state_nxt = tds_pkg::S_DEND;
      end
      tds_pkg::S_DEND: begin
        if (fault_r == tds_pkg::FAULT_NONE && qr.ovf) fault_nxt = tds_pkg::FAULT_SAT;
        if (!dsel_r) begin
          cs_we = 1'b1; cs_wdata = qr.val;
          ld_num = num_r;
          ld_mag = ld_num[DW-1] ? (~ld_num + 1'b1) : ld_num;
          dq_nxt = {ld_mag, {tds_pkg::FRAC_W{1'b0}}};
          rem_nxt = '0;
          dsgn_nxt = ld_num[DW-1] ^ den_r[DW-1];
          step_nxt = '0; dsel_nxt = 1'b1;
          state_nxt = tds_pkg::S_DIV;
        end else begin
          ds_we = 1'b1; ds_wdata = qr.val;
          row_cnt_nxt = row_cnt_r + 1'b1;
          if (last_r) begin
            idx_nxt = row_cnt_r[RW-1:0]; top_nxt = 1'b1;
            state_nxt = tds_pkg::S_BRD;
          end else begin
            state_nxt = tds_pkg::S_IDLE;
          end
        end
      end
      tds_pkg::S_BRD: state_nxt = tds_pkg::S_BMUL;
      tds_pkg::S_BMUL: begin
        mul_x = cs_rdata; mul_y = xprev_r;
        if (top_r) begin
          sol_nxt = ds_rdata; ostat_nxt = fault_r;
          state_nxt = tds_pkg::S_OUT;
        end else begin
          state_nxt = tds_pkg::S_BSUB;
        end
      end
      tds_pkg::S_BSUB: begin
        sr = tds_pkg::sat_sub(ds_rdata, mq.val);
        sol_nxt = sr.val;
        if (fault_r == tds_pkg::FAULT_NONE && (mq.ovf || sr.ovf)) begin
          fault_nxt = tds_pkg::FAULT_SAT;
        end
        ostat_nxt = fault_nxt;
        state_nxt = tds_pkg::S_OUT;
      end
      tds_pkg::S_OUT: begin
        if (!out_stall) begin
          if (idx_r == '0) begin
            row_cnt_nxt = '0; fault_nxt = tds_pkg::FAULT_NONE;
            state_nxt = tds_pkg::S_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1; top_nxt = 1'b0; xprev_nxt = sol_r;
            state_nxt = tds_pkg::S_BRD;
          end
        end
      end
      default: state_nxt = tds_pkg::S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while a solution item waits");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_cnt_r <= CW'(tds_pkg::MAX_ROWS)) else $error("row count beyond store depth");
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_out |=> row_cnt_r == '0 && fault_r == '0)
    else $error("system state not cleared after final item");
  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fault_r != '0 && !(out_valid && !out_stall && out_last_out) |=> fault_r == $past(fault_r))
    else $error("first fault overwritten");
`endif

endmodule

@@ rtl/tds_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
